/* design/spmv_pkg.sv */
package spmv_pkg;

   localparam int VECTOR_DEPTH = 1024;
   localparam int MAX_ROWS     = 65536;
   localparam int FRAC_BITS    = 16;
   localparam int QUEUE_DEPTH  = 4;

   localparam int ADDR_W = $clog2(VECTOR_DEPTH);
   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int ACC_W  = 64;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_NONZERO = 2'd1,
      OP_ROW_END = 2'd2
   } opcode_type;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [9:0]         index;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [15:0]        row_number;
      logic signed [31:0] row_sum;
      logic               saturated;
   } rsp_type;

   typedef struct packed {
      opcode_type         op;
      logic signed [31:0] value;
      logic signed [31:0] element;
   } cmd_type;

endpackage

/* design/spmv_front.sv */
module spmv_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  spmv_pkg::req_type req_data,
   output logic              push_valid,
   input  logic              push_ready,
   output spmv_pkg::cmd_type push_data
);
   import spmv_pkg::*;

   logic signed [31:0] vec_mem [VECTOR_DEPTH];
   logic signed [31:0] elem_ff;

   logic               stage_valid_ff;
   logic               stage_valid_in;
   opcode_type         stage_op_ff;
   logic signed [31:0] stage_value_ff;
   logic               stage_in_range_ff;

   logic              take;
   logic              in_range;
   logic              keep;
   logic              is_load;
   logic              is_nonzero;
   logic [ADDR_W-1:0] addr;

   assign req_ready = !stage_valid_ff || push_ready;
   assign take      = req_valid && req_ready;
   assign in_range  = (32'(req_data.index) < VECTOR_DEPTH);
   assign addr      = ADDR_W'(req_data.index);

   always_comb begin
      is_load    = 1'b0;
      is_nonzero = 1'b0;
      keep       = 1'b0;
      unique case (req_data.opcode)
         OP_LOAD: begin
            is_load = 1'b1;
            keep    = 1'b1;
         end
         OP_NONZERO: begin
            is_nonzero = 1'b1;
            keep       = 1'b1;
         end
         OP_ROW_END: begin
            keep = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
      stage_valid_in = stage_valid_ff && !push_ready;
      if (take) begin
         stage_valid_in = keep;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         stage_op_ff       <= opcode_type'(req_data.opcode);
         stage_value_ff    <= req_data.value;
         stage_in_range_ff <= in_range;
      end
   end

   always_ff @(posedge clock) begin
      if (take && is_load && in_range) begin
         vec_mem[addr] <= req_data.value;
      end
      if (take && is_nonzero) begin
         elem_ff <= vec_mem[addr];
      end
   end

   assign push_valid        = stage_valid_ff;
   assign push_data.op      = stage_op_ff;
   assign push_data.value   = stage_value_ff;
   assign push_data.element = stage_in_range_ff ? elem_ff : '0;

endmodule

/* design/spmv_queue.sv */
module spmv_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  spmv_pkg::cmd_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output spmv_pkg::cmd_type pop_data
);
   import spmv_pkg::*;

   cmd_type           slots [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slots[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* design/spmv_back.sv */
module spmv_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  spmv_pkg::cmd_type pop_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output spmv_pkg::rsp_type rsp_data
);
   import spmv_pkg::*;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   logic                    en;

   logic                    mul_valid_ff;
   opcode_type              mul_op_ff;
   logic signed [ACC_W-1:0] prod_ff;
   logic signed [ACC_W-1:0] prod_in;

   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic                    clip_ff, clip_in;
   logic [ROW_W-1:0]        row_ff, row_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff;

   logic signed [ACC_W-1:0] sum;
   logic                    add_ovf;
   logic signed [ACC_W-1:0] sat_sum;
   logic signed [ACC_W-1:0] shifted;
   logic                    too_big;
   logic                    too_small;
   logic signed [31:0]      row_sum;
   logic                    is_row_end;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign pop_ready = en;
   assign prod_in   = pop_data.value * pop_data.element;

   assign sum     = acc_ff + prod_ff;
   assign add_ovf = (acc_ff[ACC_W-1] == prod_ff[ACC_W-1]) && (sum[ACC_W-1] != acc_ff[ACC_W-1]);
   assign sat_sum = add_ovf ? (acc_ff[ACC_W-1] ? ACC_MIN : ACC_MAX) : sum;

   assign shifted   = acc_ff >>> FRAC_BITS;
   assign too_big   = !shifted[ACC_W-1] && (|shifted[ACC_W-2:31]);
   assign too_small = shifted[ACC_W-1] && !(&shifted[ACC_W-2:31]);
   assign row_sum   = too_big   ? 32'sh7FFF_FFFF :
                      too_small ? 32'sh8000_0000 : shifted[31:0];

   assign is_row_end = mul_valid_ff && (mul_op_ff == OP_ROW_END);

   always_comb begin
      acc_in  = acc_ff;
      clip_in = clip_ff;
      row_in  = row_ff;
      if (en && mul_valid_ff) begin
         unique case (mul_op_ff)
            OP_LOAD: begin
               acc_in  = '0;
               clip_in = 1'b0;
               row_in  = '0;
            end
            OP_NONZERO: begin
               acc_in  = sat_sum;
               clip_in = clip_ff || add_ovf;
            end
            OP_ROW_END: begin
               acc_in  = '0;
               clip_in = 1'b0;
               row_in  = (row_ff == ROW_W'(MAX_ROWS-1)) ? '0 : row_ff + 1'b1;
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
      end
      rsp_valid_in = en ? is_row_end : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         acc_ff       <= '0;
         clip_ff      <= 1'b0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en) begin
            mul_valid_ff <= pop_valid;
         end
         acc_ff       <= acc_in;
         clip_ff      <= clip_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mul_op_ff <= pop_data.op;
         prod_ff   <= prod_in;
      end
      if (en && is_row_end) begin
         rsp_data_ff.row_number <= 16'(row_ff);
         rsp_data_ff.row_sum    <= row_sum;
         rsp_data_ff.saturated  <= clip_ff || too_big || too_small;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* design/sparse_matrix_vector_multiply.sv */
// CSR sparse matrix-vector multiply, one row per row-end transfer. Load transfers write a
// Q16.16 element into the 1024 x 32 vector store and restart the row count; nonzero
// transfers multiply by the stored element and add into a saturating Q32.32 accumulator;
// a row-end transfer returns the row number, the floor of the sum in Q16.16 (saturated)
// and a clip flag. One transfer per cycle is taken while the result side keeps up: the
// vector store has one write and one registered read port, and the back end does one
// 32x32 multiply and one 64-bit add per cycle. A row-end result passes the front stage,
// queue slot, multiply and result registers. The four-entry queue lets the input side keep
// taking transfers while a result waits; reading a vector entry never loaded is undefined.
module sparse_matrix_vector_multiply (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  spmv_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output spmv_pkg::rsp_type rsp_data
);
   import spmv_pkg::*;

   logic    q_push_valid;
   logic    q_push_ready;
   cmd_type q_push_data;
   logic    q_pop_valid;
   logic    q_pop_ready;
   cmd_type q_pop_data;

   spmv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_data  (q_push_data)
   );

   spmv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_data  (q_push_data),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_data   (q_pop_data)
   );

   spmv_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (q_pop_valid),
      .pop_ready (q_pop_ready),
      .pop_data  (q_pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_front_hold: assert property (@(posedge clock) disable iff (reset)
      (q_push_valid && !q_push_ready) |-> !req_ready)
      else $error("front took a transfer while its stage was blocked");

   a_back_stall: assert property (@(posedge clock) disable iff (reset)
      (q_pop_valid && !q_pop_ready) |-> (rsp_valid && !rsp_ready))
      else $error("back end stalled without result backpressure");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !q_pop_valid))
      else $error("pipeline not empty after reset");

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import spmv_pkg::*;

   localparam logic [1:0] OP_IGNORED  = 2'd3;
   localparam int         CYCLE_LIMIT = 400_000;
   localparam int         ROW_ITEMS   = 125;
   localparam longint     ACC_MAX     = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint     ACC_MIN     = 64'sh8000_0000_0000_0000;
   localparam longint     SUM_MAX     = 64'sh0000_0000_7FFF_FFFF;
   localparam longint     SUM_MIN     = 64'shFFFF_FFFF_8000_0000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   int          elem_store [VECTOR_DEPTH];
   bit          elem_written [VECTOR_DEPTH];
   int          loaded_cols [$];
   longint      acc_q32;
   bit          acc_clipped;
   logic [15:0] row_count;
   rsp_type     pending_rows [$];

   bit idle_on;
   int errors;
   int cycle_count = 0;

   sparse_matrix_vector_multiply u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic flag_mismatch(input string msg);
      if (errors < 50) $display("mismatch: %s", msg);
      errors++;
   endtask

   function automatic void model_transfer(input req_type item);
      longint prod;
      longint sum;
      longint floored;
      rsp_type row;
      case (item.opcode)
         OP_LOAD: begin
            elem_store[item.index] = $signed(item.value);
            if (!elem_written[item.index]) loaded_cols.push_back(item.index);
            elem_written[item.index] = 1'b1;
            acc_q32     = 0;
            acc_clipped = 1'b0;
            row_count   = '0;
         end
         OP_NONZERO: begin
            prod = longint'($signed(item.value)) * longint'(elem_store[item.index]);
            sum  = acc_q32 + prod;
            if (acc_q32[63] == prod[63] && sum[63] != acc_q32[63]) begin
               acc_clipped = 1'b1;
               sum = acc_q32[63] ? ACC_MIN : ACC_MAX;
            end
            acc_q32 = sum;
         end
         OP_ROW_END: begin
            floored = acc_q32 >>> FRAC_BITS;
            row.saturated = acc_clipped;
            if (floored > SUM_MAX) begin
               floored = SUM_MAX;
               row.saturated = 1'b1;
            end
            if (floored < SUM_MIN) begin
               floored = SUM_MIN;
               row.saturated = 1'b1;
            end
            row.row_number = row_count;
            row.row_sum    = floored[31:0];
            pending_rows.push_back(row);
            row_count++;
            acc_q32     = 0;
            acc_clipped = 1'b0;
         end
         default: ;
      endcase
   endfunction

   task automatic push_transfer(input logic [1:0] op, input logic [9:0] idx,
                                input logic [31:0] val);
      req_type item;
      item.opcode = op;
      item.index  = idx;
      item.value  = val;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      model_transfer(item);
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      while (pending_rows.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         8:       return 32'h7FFF_FFFF;
         9:       return 32'h8000_0000;
         6, 7:    return $urandom;
         default: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      endcase
   endfunction

   task automatic load_random();
      push_transfer(OP_LOAD, $urandom_range(0, VECTOR_DEPTH - 1), pick_value());
   endtask

   task automatic test_directed();
      idle_on = 1'b1;
      push_transfer(OP_LOAD, 10'd0, 32'h7FFF_FFFF);
      push_transfer(OP_LOAD, 10'd1023, 32'h8000_0000);
      push_transfer(OP_LOAD, 10'd512, 32'h0001_0000);
      push_transfer(OP_LOAD, 10'd341, 32'hFFFF_0000);
      push_transfer(OP_ROW_END, 10'd0, 32'h0);
      push_transfer(OP_NONZERO, 10'd512, 32'h0001_0000);
      push_transfer(OP_ROW_END, 10'd0, 32'h0);
      push_transfer(OP_NONZERO, 10'd341, 32'h0000_0001);
      push_transfer(OP_ROW_END, 10'd0, 32'h0);
      push_transfer(OP_NONZERO, 10'd0, 32'h7FFF_FFFF);
      push_transfer(OP_ROW_END, 10'd0, 32'h0);
      push_transfer(OP_NONZERO, 10'd1023, 32'h7FFF_FFFF);
      push_transfer(OP_ROW_END, 10'd0, 32'h0);
      // drive the accumulator past the top rail, step back from it, then drive it past the bottom rail
      push_transfer(OP_NONZERO, 10'd1023, 32'h8000_0000);
      push_transfer(OP_NONZERO, 10'd1023, 32'h8000_0000);
      push_transfer(OP_NONZERO, 10'd0, 32'h8000_0000);
      push_transfer(OP_ROW_END, 10'd0, 32'h0);
      repeat (3) push_transfer(OP_NONZERO, 10'd0, 32'h8000_0000);
      push_transfer(OP_ROW_END, 10'd0, 32'h0);
      push_transfer(OP_IGNORED, 10'h3FF, 32'hFFFF_FFFF);
      // a load in the middle of a row drops the partial sum and restarts the count
      push_transfer(OP_NONZERO, 10'd512, 32'h0001_0000);
      push_transfer(OP_LOAD, 10'd2, 32'h0002_8000);
      push_transfer(OP_ROW_END, 10'd0, 32'h0);
      push_transfer(OP_NONZERO, 10'd2, 32'hFFFF_8000);
      push_transfer(OP_ROW_END, 10'd0, 32'h0);
   endtask

   task automatic test_back_to_back();
      idle_on = 1'b0;
      push_transfer(OP_LOAD, 10'd7, pick_value());
      repeat (16) push_transfer(OP_ROW_END, $urandom, $urandom);
      push_transfer(OP_NONZERO, 10'd7, pick_value());
      push_transfer(OP_ROW_END, $urandom, $urandom);
   endtask

   task automatic test_random_rows();
      int epoch_items;
      int nz;
      for (int epoch = 0; epoch < 4; epoch++) begin
         idle_on = (epoch == 0 || epoch == 2 || (epoch == 1 && $urandom_range(0, 1) == 1));
         epoch_items = $urandom_range(8, 24);
         repeat (epoch_items) load_random();
         while (epoch_items < ROW_ITEMS) begin
            nz = $urandom_range(0, 8);
            repeat (nz) begin
               if ($urandom_range(0, 19) == 0) push_transfer(OP_IGNORED, $urandom, $urandom);
               if ($urandom_range(0, 39) == 0) begin
                  load_random();
                  epoch_items++;
               end
               push_transfer(OP_NONZERO, loaded_cols[$urandom_range(0, loaded_cols.size() - 1)],
                             pick_value());
            end
            push_transfer(OP_ROW_END, $urandom, $urandom);
            epoch_items += nz + 1;
         end
         if (epoch == 1) hold_until_drained();
      end
   endtask

   initial begin
      int unsigned stall;
      stall = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall > 0) stall--;
         else if (idle_on && $urandom_range(0, 4) == 0) stall = $urandom_range(1, 9);
         rsp_ready <= (stall == 0);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rows.size() == 0) begin
            flag_mismatch($sformatf("unexpected row %0d", rsp_data.row_number));
         end else begin
            want = pending_rows.pop_front();
            if (rsp_data.row_number !== want.row_number)
               flag_mismatch($sformatf("row_number %0d, want %0d",
                                       rsp_data.row_number, want.row_number));
            if (rsp_data.row_sum !== want.row_sum)
               flag_mismatch($sformatf("row %0d row_sum %h, want %h", want.row_number,
                                       rsp_data.row_sum, want.row_sum));
            if (rsp_data.saturated !== want.saturated)
               flag_mismatch($sformatf("row %0d saturated %b, want %b", want.row_number,
                                       rsp_data.saturated, want.saturated));
         end
      end
   end

   initial begin
      errors      = 0;
      acc_q32     = 0;
      acc_clipped = 1'b0;
      row_count   = '0;
      idle_on     = 1'b0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_back_to_back();
      test_random_rows();
      hold_until_drained();
      repeat (16) @(posedge clock);
      if (pending_rows.size() != 0) flag_mismatch("rows still expected at end");
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

/* filelist.f */
design/spmv_pkg.sv
design/spmv_front.sv
design/spmv_queue.sv
design/spmv_back.sv
design/sparse_matrix_vector_multiply.sv
tb/sv/tb_top.sv
